// ----- hdl/chl_pkg.sv -----
// Package for the circular heading low-pass filter.
// Holds the transaction structs, register map, constants and serial step counts.
// No dependencies; used by chl_arith and circular_heading_lowpass.
package chl_pkg;

    // Widths of the arithmetic operands.
    localparam int MAG_W = 25;   // magnitude of a shortest-arc difference
    localparam int DT_W  = 20;   // effective time gap, bounded by the gap limit
    localparam int DEN_W = 21;   // tau + dt
    localparam int SPD_W = 31;
    localparam int KMH_W = 30;
    localparam int HDG_W = 26;

    // Serial step counts: one multiplier bit, then one quotient bit per cycle.
    localparam int MUL_STEPS   = DT_W;
    localparam int DIV_STEPS   = MAG_W;
    localparam int SPD_DIVIDEND_W = SPD_W + 4;
    localparam int SPEED_STEPS = SPD_DIVIDEND_W;
    localparam int LAST_STEP   = MUL_STEPS + DIV_STEPS - 1;
    localparam int STEP_W      = $clog2(LAST_STEP + 1);

    localparam logic [4:0] SPEED_DIVISOR = 5'd25;

    localparam int FULL_TURN = 36000000;
    localparam int HALF_TURN = 18000000;

    // Register map, index = paddr[3:2].
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_TIME_CONSTANT = 2'd0;
    localparam logic [1:0] REG_GAP_LIMIT     = 2'd1;
    localparam logic [1:0] REG_MIN_SPEED     = 2'd2;

    localparam logic [15:0] TIME_CONSTANT_RESET = 16'd700;
    localparam logic [19:0] GAP_LIMIT_RESET     = 20'd5000;
    localparam logic [19:0] MIN_SPEED_RESET     = 20'd5556;

    typedef struct packed {
        logic               fix_valid;
        logic [31:0]        time_of_week_ms;
        logic [30:0]        ground_speed;
        logic signed [27:0] raw_heading;
    } in_item_t;

    typedef struct packed {
        logic [30:0] speed_out;
        logic [29:0] speed_kmh_centi;
        logic [25:0] heading_filtered;
        logic        heading_ok;
        logic        fix_ok;
    } out_item_t;

    // Operands handed to the serial arithmetic unit.
    typedef struct packed {
        logic [MAG_W-1:0] diff_mag;
        logic [DT_W-1:0]  dt;
        logic [DEN_W-1:0] den;
        logic [SPD_W-1:0] speed;
    } arith_req_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [KMH_W-1:0] kmh;
    } arith_res_t;

endpackage

// ----- hdl/circular_heading_lowpass.sv -----
// Circular first-order low-pass filter on a receiver heading, top level.
// Input channel: in_valid/in_ready with one in_item_t fix per transaction.
// Output channel: out_valid/out_ready with one out_item_t result per fix.
// Configuration: APB-style port, registers at 0x0 (time constant, ms),
// 0x4 (gap limit, ms) and 0x8 (minimum heading speed, mm/s); pready is
// always high and reads return the register value.
// A valid fix passes through ST_PREP, ST_LOAD, ST_RUN and ST_POST before
// out_valid; in ST_RUN the serial unit works one multiplier bit and then one
// quotient bit per cycle. A new fix is taken in the cycle after the previous
// result is loaded, so only one fix is in flight at a time. An invalid fix
// bypasses the serial unit and goes from ST_IDLE straight to ST_POST.
// The finished result sits in an output register, so the next fix can be
// taken while the receiver stalls; only the following result then waits.
// Reset clears the filter state and loads the register defaults.
// Depends on chl_pkg and chl_arith.
module circular_heading_lowpass
    import chl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_RUN,
        ST_POST
    } state_t;

    localparam logic signed [28:0] FULL_S = 29'(FULL_TURN);
    localparam logic signed [26:0] HALF_D = 27'(HALF_TURN);
    localparam logic signed [26:0] FULL_D = 27'(FULL_TURN);
    localparam logic signed [27:0] FULL_N = 28'(FULL_TURN);

    state_t             state_reg;
    logic [15:0]        tau_reg;
    logic [19:0]        gap_reg;
    logic [19:0]        min_speed_reg;
    logic               started_reg;
    logic [HDG_W-1:0]   hs_reg;
    logic [31:0]        prev_time_reg;
    in_item_t           in_reg;
    logic [HDG_W-1:0]   h_reg;
    logic [DT_W-1:0]    dt_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               cfg_write;
    logic               in_fire;
    logic               slot_free;
    logic               arith_start;
    logic               arith_done;
    arith_req_t         arith_req;
    arith_res_t         arith_res;

    logic signed [28:0] raw_ext;
    logic signed [28:0] wrapped;
    logic [HDG_W-1:0]   h_next;
    logic [31:0]        dt_full;
    logic [DT_W-1:0]    dt_next;
    logic signed [26:0] diff0;
    logic signed [26:0] diff;
    logic [26:0]        diff_abs;
    logic signed [27:0] moved;
    logic signed [27:0] moved_wrapped;
    logic [HDG_W-1:0]   hs_new;
    out_item_t          result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = state_reg == ST_IDLE;
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_TIME_CONSTANT: prdata = {16'd0, tau_reg};
            REG_GAP_LIMIT:     prdata = {12'd0, gap_reg};
            REG_MIN_SPEED:     prdata = {12'd0, min_speed_reg};
            default:           prdata = '0;
        endcase
    end

    // Single wrap of the raw heading, then a clamp into one turn.
    always_comb
    begin
        raw_ext = 29'(in_reg.raw_heading);
        if (raw_ext < 0)
            wrapped = raw_ext + FULL_S;
        else if (raw_ext >= FULL_S)
            wrapped = raw_ext - FULL_S;
        else
            wrapped = raw_ext;
        if (wrapped < 0)
            h_next = '0;
        else if (wrapped > FULL_S - 29'sd1)
            h_next = HDG_W'(FULL_TURN - 1);
        else
            h_next = wrapped[HDG_W-1:0];

        dt_full = in_reg.time_of_week_ms - prev_time_reg;
        dt_next = (dt_full > {12'd0, gap_reg}) ? '0 : dt_full[DT_W-1:0];
    end

    // Shortest-arc difference between the new heading and the stored one.
    always_comb
    begin
        diff0 = $signed({1'b0, h_reg}) - $signed({1'b0, hs_reg});
        if (diff0 > HALF_D)
            diff = diff0 - FULL_D;
        else if (diff0 < -HALF_D)
            diff = diff0 + FULL_D;
        else
            diff = diff0;
        diff_abs = diff < 0 ? 27'(-diff) : 27'(diff);
    end

    assign arith_start        = state_reg == ST_LOAD;
    assign arith_req.diff_mag = diff_abs[MAG_W-1:0];
    assign arith_req.dt       = dt_reg;
    assign arith_req.den      = {5'd0, tau_reg} + {1'b0, dt_reg};
    assign arith_req.speed    = in_reg.ground_speed;

    chl_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (arith_start),
        .req   (arith_req),
        .done  (arith_done),
        .res   (arith_res)
    );

    // Apply the filter step and build the result.
    always_comb
    begin
        moved = $signed({2'b00, hs_reg}) +
                (neg_reg ? -$signed({3'b000, arith_res.mag}) : $signed({3'b000, arith_res.mag}));
        if (moved < 0)
            moved_wrapped = moved + FULL_N;
        else if (moved >= FULL_N)
            moved_wrapped = moved - FULL_N;
        else
            moved_wrapped = moved;

        if (!started_reg)
            hs_new = h_reg;
        else if (dt_reg != '0)
            hs_new = moved_wrapped[HDG_W-1:0];
        else
            hs_new = hs_reg;

        if (in_reg.fix_valid)
        begin
            result.speed_out        = in_reg.ground_speed;
            result.speed_kmh_centi  = arith_res.kmh;
            result.heading_filtered = hs_new;
            result.heading_ok       = in_reg.ground_speed >= {11'd0, min_speed_reg};
            result.fix_ok           = 1'b1;
        end
        else
        begin
            result = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tau_reg       <= TIME_CONSTANT_RESET;
            gap_reg       <= GAP_LIMIT_RESET;
            min_speed_reg <= MIN_SPEED_RESET;
            started_reg   <= 1'b0;
            hs_reg        <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_TIME_CONSTANT: tau_reg <= pwdata[15:0];
                    REG_GAP_LIMIT:     gap_reg <= pwdata[19:0];
                    REG_MIN_SPEED:     min_speed_reg <= pwdata[19:0];
                    default:           ;
                endcase
            end

            // In ST_POST the output register is reloaded below instead.
            if (out_valid_reg && out_ready && state_reg != ST_POST)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= in_item.fix_valid ? ST_PREP : ST_POST;
                end
                ST_PREP:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                    state_reg <= ST_RUN;
                ST_RUN:
                begin
                    if (arith_done)
                        state_reg <= ST_POST;
                end
                ST_POST:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (in_reg.fix_valid)
                        begin
                            started_reg   <= 1'b1;
                            hs_reg        <= hs_new;
                            prev_time_reg <= in_reg.time_of_week_ms;
                        end
                        else
                        begin
                            started_reg   <= 1'b0;
                            hs_reg        <= '0;
                            prev_time_reg <= '0;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_reg <= in_item;
        if (state_reg == ST_PREP)
        begin
            h_reg  <= h_next;
            dt_reg <= dt_next;
        end
        if (state_reg == ST_LOAD)
            neg_reg <= diff < 0;
        if (state_reg == ST_POST && slot_free)
            out_reg <= result;
    end

endmodule

// ----- hdl/chl_arith.sv -----
// Bit-serial arithmetic for the heading filter: |diff|*dt/(tau+dt) by shift-add
// multiply and restoring division, plus speed*9/25 by restoring division.
// Depends on chl_pkg.
module chl_arith
    import chl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  arith_req_t req,
    output logic       done,
    output arith_res_t res
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [MAG_W-1:0]          mcand_reg, mcand_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [MAG_W:0]            acc_reg, acc_next;
    logic [DT_W-1:0]           mlow_reg, mlow_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [MAG_W-1:0]          quo_reg, quo_next;
    logic [4:0]                sp_rem_reg, sp_rem_next;
    logic [SPD_DIVIDEND_W-1:0] sp_quo_reg, sp_quo_next;

    logic [MAG_W:0]            sum;
    logic [DEN_W:0]            trial;
    logic                      trial_ge;
    logic [5:0]                sp_trial;
    logic                      sp_ge;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        mcand_next  = mcand_reg;
        den_next    = den_reg;
        acc_next    = acc_reg;
        mlow_next   = mlow_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        sp_rem_next = sp_rem_reg;
        sp_quo_next = sp_quo_reg;

        sum      = acc_reg + (mlow_reg[0] ? {1'b0, mcand_reg} : '0);
        trial    = {rem_reg, quo_reg[MAG_W-1]};
        trial_ge = trial >= {1'b0, den_reg};
        sp_trial = {sp_rem_reg, sp_quo_reg[SPD_DIVIDEND_W-1]};
        sp_ge    = sp_trial >= {1'b0, SPEED_DIVISOR};

        if (start)
        begin
            busy_next   = 1'b1;
            step_next   = '0;
            mcand_next  = req.diff_mag;
            den_next    = req.den;
            acc_next    = '0;
            mlow_next   = req.dt;
            sp_rem_next = '0;
            sp_quo_next = {1'b0, req.speed, 3'b000} + {4'b0000, req.speed};
        end
        else if (busy_reg)
        begin
            if (step_reg < STEP_W'(MUL_STEPS))
            begin
                // LSB-first shift-add; the product ends up in {acc, mlow}.
                acc_next  = {1'b0, sum[MAG_W:1]};
                mlow_next = {sum[0], mlow_reg[DT_W-1:1]};
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    // The quotient fits in MAG_W bits, so the top product bits
                    // are already below the divisor and seed the remainder.
                    rem_next = acc_next[MAG_W-1 -: DEN_W-1] == '0 ?
                               {1'b0, acc_next[MAG_W-1:MAG_W-DEN_W+1]} :
                               {1'b0, acc_next[MAG_W-1:MAG_W-DEN_W+1]};
                    quo_next = {acc_next[MAG_W-DEN_W:0], mlow_next};
                end
            end
            else
            begin
                rem_next = trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], trial_ge};
            end

            if (step_reg < STEP_W'(SPEED_STEPS))
            begin
                sp_rem_next = sp_ge ? 5'(sp_trial - {1'b0, SPEED_DIVISOR}) : sp_trial[4:0];
                sp_quo_next = {sp_quo_reg[SPD_DIVIDEND_W-2:0], sp_ge};
            end

            if (step_reg == STEP_W'(LAST_STEP))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        den_reg    <= den_next;
        acc_reg    <= acc_next;
        mlow_reg   <= mlow_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sp_rem_reg <= sp_rem_next;
        sp_quo_reg <= sp_quo_next;
    end

    assign done    = done_reg;
    assign res.mag = quo_reg;
    assign res.kmh = sp_quo_reg[KMH_W-1:0];

endmodule
